[rtl/dpt_pkg.sv]
// Shared types, field widths and codes for the dirty page tracker.
package dpt_pkg;

    localparam int ADDR_W   = 48;
    localparam int CMD_W    = 2;
    localparam int PID_W    = 3;
    localparam int STATUS_W = 3;
    localparam int PAGE_W   = 6;
    localparam int BYTES_W  = 19;
    localparam int COUNT_W  = 32;
    localparam int MAP_W    = 64;
    localparam int ROW_W    = 6;

    localparam logic [BYTES_W-1:0] BYTES_MAX = {BYTES_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [CMD_W-1:0] CMD_MARK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CKPT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_NEW     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ALREADY = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OOR     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LOGGED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd5;

    typedef struct packed {
        logic [MAP_W-1:0]   map;
        logic [BYTES_W-1:0] bytes;
        logic [COUNT_W-1:0] count;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] idx;
    } t_mem_rd;

    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] idx;
        t_entry           data;
    } t_mem_wr;

    typedef struct packed {
        logic              done;
        logic              oor;
        logic [PAGE_W-1:0] page;
    } t_map_res;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PAGE_W-1:0]   page;
        logic [BYTES_W-1:0]  bytes;
        logic [COUNT_W-1:0]  count;
        logic                last;
    } t_result;

endpackage

[rtl/dpt_base_mod.sv]
// Area base register and its residue modulo the page size, sixteen base bits per step.
module dpt_base_mod #(
    parameter int PAGE_BYTES = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [dpt_pkg::ADDR_W-1:0]  i_cfg_data,
    output logic [dpt_pkg::ADDR_W-1:0]  o_base,
    output logic [$clog2(PAGE_BYTES)-1:0] o_base_mod,
    output logic                        o_busy
);
    import dpt_pkg::*;

    localparam int R_W    = $clog2(PAGE_BYTES);
    localparam int DIG_W  = 16;
    localparam int DIGITS = ADDR_W / DIG_W;
    localparam longint unsigned RECIP = (64'd1 << 32) / PAGE_BYTES;
    localparam logic [31:0] M_C = 32'(RECIP);
    localparam logic [31:0] P_W = 32'(PAGE_BYTES);

    localparam logic [1:0] PH_MUL = 2'd0;
    localparam logic [1:0] PH_SUB = 2'd1;
    localparam logic [1:0] PH_FIX = 2'd2;

    logic [ADDR_W-1:0] r_base;
    logic [ADDR_W-1:0] r_shift;
    logic [R_W-1:0]    r_rem;
    logic [31:0]       r_val;
    logic [31:0]       r_quo;
    logic [31:0]       r_part;
    logic [1:0]        r_phase;
    logic [1:0]        r_digit;
    logic              r_busy;
    logic [31:0]       val;
    logic [63:0]       prod;

    // Each step folds the next 16 base bits into the running residue. The
    // reciprocal quotient is at most one low, so one compare and subtract
    // finishes the step.
    assign val  = {16'(r_rem), r_shift[ADDR_W-1 -: DIG_W]};
    assign prod = 64'(val) * 64'(M_C);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_shift <= '0;
            r_rem   <= '0;
            r_phase <= PH_MUL;
            r_digit <= '0;
            r_busy  <= 1'b0;
        end else if (i_cfg_we) begin
            r_base  <= i_cfg_data;
            r_shift <= i_cfg_data;
            r_rem   <= '0;
            r_phase <= PH_MUL;
            r_digit <= '0;
            r_busy  <= 1'b1;
        end else if (r_busy) begin
            unique case (r_phase)
                PH_MUL: begin
                    r_val   <= val;
                    r_quo   <= prod[63:32];
                    r_phase <= PH_SUB;
                end
                PH_SUB: begin
                    r_part  <= r_val - (r_quo * P_W);
                    r_phase <= PH_FIX;
                end
                PH_FIX: begin
                    r_rem   <= R_W'((r_part >= P_W) ? r_part - P_W : r_part);
                    r_shift <= r_shift << DIG_W;
                    r_digit <= r_digit + 1'b1;
                    r_phase <= PH_MUL;
                    if (r_digit == 2'(DIGITS - 1)) begin
                        r_busy <= 1'b0;
                    end
                end
                default: begin
                    r_phase <= PH_MUL;
                end
            endcase
        end
    end

    assign o_base     = r_base;
    assign o_base_mod = r_rem;
    assign o_busy     = r_busy;

endmodule

[rtl/dpt_page_map.sv]
// Address to page pipeline: area offset, range check and division by the page size.
module dpt_page_map #(
    parameter int PAGES_PER_AREA = 64,
    parameter int PAGE_BYTES     = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [dpt_pkg::PID_W-1:0]     i_pid,
    input  logic [dpt_pkg::ADDR_W-1:0]    i_addr,
    input  logic [dpt_pkg::ADDR_W-1:0]    i_base,
    input  logic [$clog2(PAGE_BYTES)-1:0] i_base_mod,
    output dpt_pkg::t_map_res             o_res
);
    import dpt_pkg::*;

    localparam int R_W        = $clog2(PAGE_BYTES);
    localparam int AREA_BYTES = PAGES_PER_AREA * PAGE_BYTES;
    localparam int E_W        = $clog2(AREA_BYTES + 2 * PAGE_BYTES);
    localparam int Q_W        = $clog2(PAGES_PER_AREA + 2);
    localparam int SH         = E_W + 1;
    localparam int M_W        = SH + 1;
    localparam int PROD_W     = E_W + M_W;
    localparam longint unsigned RECIP = (64'd1 << SH) / PAGE_BYTES;

    localparam logic [ADDR_W:0]   AREA_C = (ADDR_W+1)'(AREA_BYTES);
    localparam logic [ADDR_W+1:0] LIMIT  = (ADDR_W+2)'(AREA_BYTES + PAGE_BYTES);
    localparam logic [M_W-1:0]    M_C    = M_W'(RECIP);
    localparam logic [E_W-1:0]    P_E    = E_W'(PAGE_BYTES);
    localparam logic [Q_W-1:0]    PAGES_Q = Q_W'(PAGES_PER_AREA);

    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W:0]   r_start;
    logic [ADDR_W+1:0] r_diff;
    logic              r_oor_a;
    logic [E_W-1:0]    r_e;
    logic [Q_W-1:0]    r_q0;
    logic [E_W-1:0]    r_rem;
    logic [4:0]        r_v;
    logic              r_done;
    logic              r_oor;
    logic [PAGE_W-1:0] r_page;

    logic [PROD_W-1:0] prod;
    logic [Q_W-1:0]    q;
    logic [Q_W-1:0]    page_full;
    logic              bm_nz;

    assign prod  = PROD_W'(r_e) * PROD_W'(M_C);
    assign bm_nz = (i_base_mod != '0);
    assign q     = (r_rem >= P_E) ? r_q0 + 1'b1 : r_q0;
    // The area start need not be page aligned: with a nonzero residue the
    // rounded address lands one page lower than the plain quotient.
    assign page_full = q - Q_W'(bm_nz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= '0;
            r_done <= 1'b0;
        end else begin
            r_v <= {r_v[3:0], i_start};
            if (i_start) begin
                r_done <= 1'b0;
            end else if (r_v[4]) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_addr  <= i_addr;
            r_start <= {1'b0, i_base} + ((ADDR_W+1)'(i_pid) * AREA_C);
        end
        if (r_v[0]) begin
            r_diff <= {2'b00, r_addr} - {1'b0, r_start};
        end
        if (r_v[1]) begin
            r_oor_a <= r_diff[ADDR_W+1] || (r_diff >= LIMIT);
            r_e     <= E_W'(r_diff) + E_W'(i_base_mod);
        end
        if (r_v[2]) begin
            r_q0 <= prod[SH +: Q_W];
        end
        if (r_v[3]) begin
            r_rem <= r_e - (E_W'(r_q0) * P_E);
        end
        if (r_v[4]) begin
            r_oor  <= r_oor_a || ((q == '0) && bm_nz) || (page_full >= PAGES_Q);
            r_page <= PAGE_W'(page_full);
        end
    end

    assign o_res.done = r_done;
    assign o_res.oor  = r_oor;
    assign o_res.page = r_page;

endmodule

[rtl/dpt_state_mem.sv]
// Per process state memory with valid bits that reset clears.
module dpt_state_mem #(
    parameter int PROCESSES = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dpt_pkg::t_mem_rd  i_rd,
    input  dpt_pkg::t_mem_wr  i_wr,
    output dpt_pkg::t_entry   o_rdata
);
    import dpt_pkg::*;

    localparam int IDX_W = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;

    t_entry               mem [PROCESSES];
    logic [PROCESSES-1:0] r_valid;
    t_entry               r_rdata;
    logic                 r_rvalid;
    logic [IDX_W-1:0]     ridx;
    logic [IDX_W-1:0]     widx;

    assign ridx = i_rd.idx[IDX_W-1:0];
    assign widx = i_wr.idx[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[widx] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rdata <= mem[ridx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[widx] <= 1'b1;
            end
            if (i_rd.en) begin
                r_rvalid <= r_valid[ridx];
            end
        end
    end

    // An entry never written since reset reads as all zeros.
    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

[rtl/dirty_page_tracker_unit.sv]
// Dirty page tracker: command sequencer, output register and submodule wiring.
//
// Commands enter on the input channel (i_in_valid / o_in_stall) and results
// leave on the output channel (o_out_valid / i_out_stall); a beat moves at a
// clock edge with valid high and stall low. The area base is written on the
// configuration channel (i_cfg_valid / o_cfg_ready), which is always ready.
// One command is worked on at a time. Its state row is read from the state
// memory at acceptance and written back at the end if the command changes it.
// Mark: each command waits on the six stage address to page pipeline.
// Checkpoint: the scan runs from page 0 to the highest dirty page, one page
// index per cycle while the output is free; an empty checkpoint or a counter
// reset is answered from the dispatch state. After each base write the input
// stalls while the base residue modulo the page size forms in three steps.
// The output register holds one result; while the receiver stalls the
// sequencer waits with the next result, and a new command is still accepted
// once the previous one has issued its last result.
// Synchronous active low reset clears all process state, the base and the
// output valid flag; the memory rows read as zero until first written.
module dirty_page_tracker_unit #(
    parameter int PROCESSES      = 8,
    parameter int PAGES_PER_AREA = 64,
    parameter int PAGE_BYTES     = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dpt_pkg::ADDR_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [dpt_pkg::CMD_W-1:0]     i_cmd,
    input  logic [dpt_pkg::PID_W-1:0]     i_process_id,
    input  logic [dpt_pkg::ADDR_W-1:0]    i_write_address,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [dpt_pkg::STATUS_W-1:0]  o_status,
    output logic [dpt_pkg::PAGE_W-1:0]    o_page_index,
    output logic [dpt_pkg::BYTES_W-1:0]   o_log_bytes,
    output logic [dpt_pkg::COUNT_W-1:0]   o_tracked_count,
    output logic                          o_last
);
    import dpt_pkg::*;

    localparam int R_W = $clog2(PAGE_BYTES);
    localparam logic [BYTES_W-1:0] P_B  = BYTES_W'(PAGE_BYTES);
    localparam logic [BYTES_W:0]   P_B1 = (BYTES_W+1)'(PAGE_BYTES);
    localparam logic [PID_W+3:0]   PROC_C = (PID_W+4)'(PROCESSES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DISP = 2'd1;
    localparam logic [1:0] S_MARK = 2'd2;
    localparam logic [1:0] S_SCAN = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [CMD_W-1:0]   r_cmd;
    logic [PID_W-1:0]   r_pid;
    logic [MAP_W-1:0]   r_map, n_map;
    logic [BYTES_W-1:0] r_bytes, n_bytes;
    logic [PAGE_W-1:0]  r_idx, n_idx;
    logic               r_out_valid;
    t_result            r_out;

    logic [ADDR_W-1:0]  base;
    logic [R_W-1:0]     base_mod;
    logic               mod_busy;
    t_map_res           map_res;
    t_mem_rd            mem_rd;
    t_mem_wr            mem_wr;
    t_entry             rdata;
    t_result            res;
    logic               emit;
    logic               in_acc;
    logic               out_free;
    logic               pid_oob;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE) || mod_busy;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign pid_oob     = ({4'b0000, r_pid} >= PROC_C);

    assign mem_rd.en  = in_acc;
    assign mem_rd.idx = ROW_W'(i_process_id);

    dpt_base_mod #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_base_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_base     (base),
        .o_base_mod (base_mod),
        .o_busy     (mod_busy)
    );

    dpt_page_map #(
        .PAGES_PER_AREA (PAGES_PER_AREA),
        .PAGE_BYTES     (PAGE_BYTES)
    ) u_page_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_acc && (i_cmd == CMD_MARK)),
        .i_pid      (i_process_id),
        .i_addr     (i_write_address),
        .i_base     (base),
        .i_base_mod (base_mod),
        .o_res      (map_res)
    );

    dpt_state_mem #(
        .PROCESSES (PROCESSES)
    ) u_state_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (mem_rd),
        .i_wr    (mem_wr),
        .o_rdata (rdata)
    );

    always_comb begin
        logic [COUNT_W-1:0] cnt_inc;
        logic [BYTES_W:0]   sum;
        logic [BYTES_W-1:0] bytes_add;
        logic [BYTES_W-1:0] bytes_sub;
        logic [MAP_W-1:0]   cleared;

        n_state    = r_state;
        n_map      = r_map;
        n_bytes    = r_bytes;
        n_idx      = r_idx;
        emit       = 1'b0;
        res        = '0;
        res.last   = 1'b1;
        mem_wr     = '0;
        mem_wr.idx = ROW_W'(r_pid);

        cnt_inc   = (rdata.count == COUNT_MAX) ? rdata.count : rdata.count + 1'b1;
        sum       = {1'b0, rdata.bytes} + P_B1;
        bytes_add = (sum > {1'b0, BYTES_MAX}) ? BYTES_MAX : BYTES_W'(sum);
        bytes_sub = (r_bytes < P_B) ? '0 : r_bytes - P_B;
        cleared   = r_map & ~(MAP_W'(1) << r_idx);

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                priority if (r_cmd == CMD_NONE) begin
                    n_state = S_IDLE;
                end else if (pid_oob) begin
                    if (out_free) begin
                        emit       = 1'b1;
                        res.status = ST_OOR;
                        n_state    = S_IDLE;
                    end
                end else if (r_cmd == CMD_MARK) begin
                    n_state = S_MARK;
                end else if (r_cmd == CMD_CKPT) begin
                    if (rdata.map == '0) begin
                        if (out_free) begin
                            emit       = 1'b1;
                            res.status = ST_EMPTY;
                            res.bytes  = rdata.bytes;
                            res.count  = rdata.count;
                            n_state    = S_IDLE;
                        end
                    end else begin
                        n_map   = rdata.map;
                        n_bytes = rdata.bytes;
                        n_idx   = '0;
                        n_state = S_SCAN;
                    end
                end else begin
                    // Counter reset keeps the dirty bits.
                    if (out_free) begin
                        emit              = 1'b1;
                        res.status        = ST_CLEARED;
                        mem_wr.en         = 1'b1;
                        mem_wr.data.map   = rdata.map;
                        mem_wr.data.bytes = '0;
                        mem_wr.data.count = '0;
                        n_state           = S_IDLE;
                    end
                end
            end
            S_MARK: begin
                if (map_res.done && out_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                    if (map_res.oor) begin
                        res.status = ST_OOR;
                        res.bytes  = rdata.bytes;
                        res.count  = rdata.count;
                    end else begin
                        mem_wr.en         = 1'b1;
                        mem_wr.data.count = cnt_inc;
                        res.page          = map_res.page;
                        res.count         = cnt_inc;
                        if (!rdata.map[map_res.page]) begin
                            mem_wr.data.map   = rdata.map | (MAP_W'(1) << map_res.page);
                            mem_wr.data.bytes = bytes_add;
                            res.status        = ST_NEW;
                            res.bytes         = bytes_add;
                        end else begin
                            mem_wr.data.map   = rdata.map;
                            mem_wr.data.bytes = rdata.bytes;
                            res.status        = ST_ALREADY;
                            res.bytes         = rdata.bytes;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (!r_map[r_idx]) begin
                    n_idx = r_idx + 1'b1;
                end else if (out_free) begin
                    // Lower bits are already cleared, so the page is the last
                    // one exactly when nothing is left in the map.
                    emit       = 1'b1;
                    res.status = ST_LOGGED;
                    res.page   = r_idx;
                    res.bytes  = bytes_sub;
                    res.count  = rdata.count;
                    res.last   = (cleared == '0);
                    n_map      = cleared;
                    n_bytes    = bytes_sub;
                    if (cleared == '0) begin
                        mem_wr.en         = 1'b1;
                        mem_wr.data.map   = '0;
                        mem_wr.data.bytes = bytes_sub;
                        mem_wr.data.count = rdata.count;
                        n_state           = S_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd <= i_cmd;
            r_pid <= i_process_id;
        end
        if (emit) begin
            r_out <= res;
        end
        r_map   <= n_map;
        r_bytes <= n_bytes;
        r_idx   <= n_idx;
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out.status;
    assign o_page_index    = r_out.page;
    assign o_log_bytes     = r_out.bytes;
    assign o_tracked_count = r_out.count;
    assign o_last          = r_out.last;

endmodule

[verif/dirty_page_tracker_unit_tb.sv]
// Self-checking testbench for the dirty page tracker unit: directed and random commands.
`timescale 1ns / 100ps

module dirty_page_tracker_unit_tb;
    import dpt_pkg::*;

    localparam int PROCESSES      = 8;
    localparam int PAGES_PER_AREA = 64;
    localparam int PAGE_BYTES     = 4096;
    localparam logic [63:0] AREA_BYTES = 64'(PAGES_PER_AREA) * 64'(PAGE_BYTES);
    // Longest quiet time the block needs: a full scan or the base residue pass.
    localparam int SETTLE_CYCLES  = 100;

    class dirty_log_scoreboard;
        logic [ADDR_W-1:0]  area_base;
        logic [MAP_W-1:0]   dirty_rows [PROCESSES];
        logic [BYTES_W-1:0] log_bytes  [PROCESSES];
        logic [COUNT_W-1:0] mark_tally [PROCESSES];
        t_result            expected_beats [$];
        int                 errors;

        function new();
            area_base = '0;
            errors    = 0;
            foreach (dirty_rows[i]) begin
                dirty_rows[i] = '0;
                log_bytes[i]  = '0;
                mark_tally[i] = '0;
            end
        endfunction

        function void expect_beat(logic [STATUS_W-1:0] st, int unsigned pg,
                                  logic [BYTES_W-1:0] b, logic [COUNT_W-1:0] c, logic l);
            t_result r;
            r.status = st;
            r.page   = PAGE_W'(pg);
            r.bytes  = b;
            r.count  = c;
            r.last   = l;
            expected_beats.push_back(r);
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [PID_W-1:0] pid,
                                   logic [ADDR_W-1:0] addr);
            logic [63:0] start;
            logic [63:0] page_addr;
            int unsigned pg;
            int          beats;
            start     = 64'(area_base) + 64'(pid) * AREA_BYTES;
            page_addr = 64'(addr) - (64'(addr) % 64'(PAGE_BYTES));
            beats     = 0;
            case (cmd)
                CMD_MARK: begin
                    if (page_addr < start || page_addr - start >= AREA_BYTES) begin
                        expect_beat(ST_OOR, 0, log_bytes[pid], mark_tally[pid], 1'b1);
                    end else begin
                        pg = int'((page_addr - start) / 64'(PAGE_BYTES));
                        if (mark_tally[pid] != COUNT_MAX)
                            mark_tally[pid] = mark_tally[pid] + 1'b1;
                        if (!dirty_rows[pid][pg]) begin
                            dirty_rows[pid][pg] = 1'b1;
                            if (log_bytes[pid] > BYTES_MAX - BYTES_W'(PAGE_BYTES))
                                log_bytes[pid] = BYTES_MAX;
                            else
                                log_bytes[pid] = log_bytes[pid] + BYTES_W'(PAGE_BYTES);
                            expect_beat(ST_NEW, pg, log_bytes[pid], mark_tally[pid], 1'b1);
                        end else begin
                            expect_beat(ST_ALREADY, pg, log_bytes[pid], mark_tally[pid],
                                        1'b1);
                        end
                    end
                end
                CMD_CKPT: begin
                    for (int i = 0; i < PAGES_PER_AREA; i++) begin
                        if (dirty_rows[pid][i]) begin
                            dirty_rows[pid][i] = 1'b0;
                            // The log never goes below zero, even after a counter reset.
                            if (log_bytes[pid] < BYTES_W'(PAGE_BYTES))
                                log_bytes[pid] = '0;
                            else
                                log_bytes[pid] = log_bytes[pid] - BYTES_W'(PAGE_BYTES);
                            expect_beat(ST_LOGGED, i, log_bytes[pid], mark_tally[pid],
                                        (dirty_rows[pid] >> i) == '0);
                            beats++;
                        end
                    end
                    if (beats == 0)
                        expect_beat(ST_EMPTY, 0, log_bytes[pid], mark_tally[pid], 1'b1);
                end
                CMD_CLEAR: begin
                    log_bytes[pid]  = '0;
                    mark_tally[pid] = '0;
                    expect_beat(ST_CLEARED, 0, '0, '0, 1'b1);
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_beat(t_result got);
            t_result want;
            if (expected_beats.size() == 0) begin
                $error("result beat with nothing expected: status %0d page %0d",
                       got.status, got.page);
                errors++;
                return;
            end
            want = expected_beats.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("page_index", want.page, got.page);
            compare_field("log_bytes", want.bytes, got.bytes);
            compare_field("tracked_count", want.count, got.count);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_valid = 1'b0;
    logic [ADDR_W-1:0]   cfg_data  = '0;
    logic                in_valid  = 1'b0;
    logic [CMD_W-1:0]    cmd_d     = CMD_MARK;
    logic [PID_W-1:0]    pid_d     = '0;
    logic [ADDR_W-1:0]   addr_d    = '0;
    logic                out_stall = 1'b0;
    logic                o_cfg_ready;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [STATUS_W-1:0] o_status;
    logic [PAGE_W-1:0]   o_page_index;
    logic [BYTES_W-1:0]  o_log_bytes;
    logic [COUNT_W-1:0]  o_tracked_count;
    logic                o_last;
    t_result             out_beat;

    int send_idle_pct  = 24;
    int recv_stall_pct = 82;

    dirty_log_scoreboard log_sb = new();

    dirty_page_tracker_unit #(
        .PROCESSES      (PROCESSES),
        .PAGES_PER_AREA (PAGES_PER_AREA),
        .PAGE_BYTES     (PAGE_BYTES)
    ) u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd           (cmd_d),
        .i_process_id    (pid_d),
        .i_write_address (addr_d),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_status        (o_status),
        .o_page_index    (o_page_index),
        .o_log_bytes     (o_log_bytes),
        .o_tracked_count (o_tracked_count),
        .o_last          (o_last)
    );

    assign out_beat = {o_status, o_page_index, o_log_bytes, o_tracked_count, o_last};

    initial begin
        forever #2 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Values read here are the ones present just before the edge.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !o_in_stall)
                log_sb.note_command(cmd_d, pid_d, addr_d);
            if (o_out_valid && !out_stall)
                log_sb.check_beat(out_beat);
        end
    end

    task automatic send_command(input logic [CMD_W-1:0] c, input logic [PID_W-1:0] p,
                                input logic [ADDR_W-1:0] a);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd_d    <= c;
        pid_d    <= p;
        addr_d   <= a;
        @(posedge clk);
        while (o_in_stall) @(posedge clk);
    endtask

    // One edge first, so the last accepted command is already noted.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (log_sb.expected_beats.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_base(input logic [ADDR_W-1:0] base);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= base;
        @(posedge clk);
        while (!o_cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        log_sb.area_base = base;
    endtask

    function automatic logic [ADDR_W-1:0] page_address(logic [PID_W-1:0] p, int unsigned pg);
        return ADDR_W'(64'(log_sb.area_base) + 64'(p) * AREA_BYTES
                       + 64'(pg) * 64'(PAGE_BYTES) + 64'($urandom_range(0, PAGE_BYTES - 1)));
    endfunction

    function automatic logic [ADDR_W-1:0] pick_address(logic [PID_W-1:0] p);
        logic [63:0] start;
        int unsigned r;
        start = 64'(log_sb.area_base) + 64'(p) * AREA_BYTES;
        r     = $urandom_range(0, 99);
        if (r < 72)
            return page_address(p, $urandom_range(0, 1) ? $urandom_range(0, 7)
                                                         : $urandom_range(0, 63));
        else if (r < 80)
            return ADDR_W'(start - 64'($urandom_range(1, 2 * PAGE_BYTES)));
        else if (r < 88)
            return ADDR_W'(start + AREA_BYTES + 64'($urandom_range(0, 2 * PAGE_BYTES)));
        else
            return ADDR_W'({$urandom, $urandom});
    endfunction

    task automatic random_commands(input int count);
        logic [PID_W-1:0] p;
        int unsigned      r;
        for (int n = 0; n < count; n++) begin
            // Most traffic goes to a few processes so pages are hit again.
            p = ($urandom_range(0, 99) < 70) ? PID_W'($urandom_range(0, 2))
                                             : PID_W'($urandom_range(0, 7));
            r = $urandom_range(0, 99);
            if (r < 62)
                send_command(CMD_MARK, p, pick_address(p));
            else if (r < 80)
                send_command(CMD_CKPT, p, ADDR_W'({$urandom, $urandom}));
            else if (r < 90)
                send_command(CMD_CLEAR, p, ADDR_W'({$urandom, $urandom}));
            else
                send_command(CMD_NONE, p, ADDR_W'({$urandom, $urandom}));
        end
    endtask

    // Dirty the top pages of one area, highest first, then take a checkpoint.
    task automatic fill_area(input logic [PID_W-1:0] p, input int pages);
        for (int pg = PAGES_PER_AREA - 1; pg >= PAGES_PER_AREA - pages; pg--)
            send_command(CMD_MARK, p, page_address(p, pg));
        send_command(CMD_CKPT, p, '0);
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Base at its reset value of zero.
        send_command(CMD_MARK, 3'd0, 48'h0);
        send_command(CMD_MARK, 3'd0, 48'hFFF);
        send_command(CMD_MARK, 3'd0, 48'h3_F000);
        send_command(CMD_MARK, 3'd7, 48'h1F_FFFF);
        send_command(CMD_MARK, 3'd1, 48'h3_FFFF);
        send_command(CMD_MARK, 3'd0, 48'h4_0000);
        send_command(CMD_MARK, 3'd3, 48'hFFFF_FFFF_FFFF);
        send_command(CMD_NONE, 3'd5, 48'hAAAA_5555_AAAA);
        send_command(CMD_CKPT, 3'd0, 48'h0);
        send_command(CMD_CKPT, 3'd0, 48'h0);
        send_command(CMD_CKPT, 3'd7, 48'h0);
        // A counter reset keeps the dirty bit, so the checkpoint finds a zero log.
        send_command(CMD_MARK, 3'd2, 48'h8_5123);
        send_command(CMD_CLEAR, 3'd2, 48'h0);
        send_command(CMD_CKPT, 3'd2, 48'h0);
        send_command(CMD_MARK, 3'd6, 48'h1A_A000);
        send_command(CMD_MARK, 3'd6, 48'h1A_3FFF);
        send_command(CMD_CKPT, 3'd6, 48'h0);
        send_command(CMD_CLEAR, 3'd4, 48'h0);
        send_command(CMD_CKPT, 3'd4, 48'h0);

        // Base at the top of the address space: no area can be reached.
        write_base(48'hFFFF_FFFF_FFFF);
        send_command(CMD_MARK, 3'd0, 48'hFFFF_FFFF_FFFF);
        send_command(CMD_MARK, 3'd7, 48'h0);
        send_command(CMD_CKPT, 3'd0, 48'h0);

        // Base not page aligned.
        write_base({16'($urandom_range(0, 16'h7FFF)), 32'($urandom)});
        random_commands(25);
        fill_area(PID_W'($urandom_range(0, 7)), PAGES_PER_AREA);

        send_idle_pct  = 82;
        recv_stall_pct = 24;
        // Last area ends exactly at the top of the address space.
        write_base(48'hFFFF_FFE0_0000);
        send_command(CMD_MARK, 3'd7, 48'hFFFF_FFFF_FFFF);
        random_commands(30);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_base(48'h0);
        fill_area(PID_W'($urandom_range(0, 7)), 16);
        random_commands(25);

        wait_idle();
        if (log_sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
rtl/dpt_pkg.sv
rtl/dpt_base_mod.sv
rtl/dpt_page_map.sv
rtl/dpt_state_mem.sv
rtl/dirty_page_tracker_unit.sv
verif/dirty_page_tracker_unit_tb.sv
